// ===== hdl/pcc_pkg.sv =====
// Shared types, codes and saturation helpers for the clamped PID controller.
`timescale 1ns / 1ps

package pcc_pkg;

    localparam int unsigned FRAC_BITS_DEF = 16;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned DATA_W      = 32;

    localparam logic OPC_COMPUTE = 1'b0;
    localparam logic OPC_RESET   = 1'b1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_KP      = 3'd0,
        REG_KI      = 3'd1,
        REG_KD      = 3'd2,
        REG_OUT_MIN = 3'd3,
        REG_OUT_MAX = 3'd4
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_STORE,
        ST_INT,
        ST_DIV,
        ST_DSAT,
        ST_SUM,
        ST_CLAMP,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        PROD_P,
        PROD_I,
        PROD_D
    } prod_t;

    // Signed 32-bit result from a magnitude and a sign, saturated.
    function automatic logic [31:0] sat_mag(input logic [63:0] m, input logic neg);
        logic [31:0] r;
        if (neg)
        begin
            r = (m > 64'h0000_0000_8000_0000) ? 32'h8000_0000 : (32'd0 - m[31:0]);
        end
        else
        begin
            r = (m > 64'h0000_0000_7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
        end
        return r;
    endfunction

    // Saturate a 34-bit signed sum to 32 bits.
    function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sh7FFF_FFFF)
        begin
            r = 32'sh7FFF_FFFF;
        end
        else if (v < -34'sh8000_0000)
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Lower limit tested first; limits off when both are zero.
    function automatic logic signed [31:0] clamp(input logic signed [31:0] v,
                                                 input logic signed [31:0] lo,
                                                 input logic signed [31:0] hi);
        logic signed [31:0] r;
        r = v;
        if (lo != 32'sd0 || hi != 32'sd0)
        begin
            if (v < lo)
            begin
                r = lo;
            end
            else if (v > hi)
            begin
                r = hi;
            end
        end
        return r;
    endfunction

endpackage

// ===== hdl/pid_controller_clamped.sv =====
// Top level of the clamped PID controller with a shared multiplier and serial divider.
`timescale 1ns / 1ps

// A compute item raises m_tvalid after three products on one 32x16
// multiplier (three slices each plus a store), integral update, 64-step restoring divide
// by dt, then saturate, sum, clamp and load. Zero-dt items go straight to the load.
// Reset items finish at accept and give no result. s_tready is high only while idle, so
// compute items wait for the last one to load; a result held by m_tready stalls the next.
// rst_n (asynchronous, active low) clears gains, limits, loop state and output valid.
module pid_controller_clamped #(
    parameter int unsigned FRAC_BITS = pcc_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [31:0] input_value, [63:32] setpoint, [95:64] preset_output, [127:96] timestamp_us
    input  logic [127:0]                      s_tdata,
    // [0] opcode
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [31:0] drive_value
    output logic [31:0]                       m_tdata,
    // [0] held
    output logic                              m_tuser,
    input  logic                              cfg_we,
    input  logic [pcc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [pcc_pkg::DATA_W-1:0]        cfg_data
);

    pcc_pkg::state_t state_reg, state_next;
    pcc_pkg::prod_t  prod_reg;

    logic [1:0]         phase_reg;
    logic [5:0]         cnt_reg;
    logic [63:0]        acc_reg;
    logic [31:0]        rem_reg;
    logic [31:0]        dt_reg;
    logic [32:0]        err_mag_reg, nd_mag_reg;
    logic               err_neg_reg, nd_neg_reg;
    logic signed [31:0] p_reg, iterm_reg, d_reg, sum_reg, res_reg;
    logic               res_held_reg;
    logic signed [31:0] integral_reg, last_input_reg;
    logic [31:0]        last_time_reg;
    logic signed [31:0] kp_reg, ki_reg, kd_reg, min_reg, max_reg;
    logic [31:0]        out_data_reg;
    logic               out_held_reg, out_valid_reg;

    // Input fields
    logic signed [31:0] in_value, in_setpoint, in_preset;
    logic [31:0]        in_time;
    logic               in_opcode;

    assign in_value    = s_tdata[31:0];
    assign in_setpoint = s_tdata[63:32];
    assign in_preset   = s_tdata[95:64];
    assign in_time     = s_tdata[127:96];
    assign in_opcode   = s_tuser;

    // Control outputs
    logic in_accept, out_load, mul_last, div_last, dt_zero;

    // Datapath
    logic [31:0]        dt_in;
    logic signed [32:0] err_in, nd_in;
    logic signed [31:0] gain;
    logic [31:0]        gain_mag;
    logic [32:0]        x_mag;
    logic               prod_neg;
    logic [15:0]        chunk;
    logic [47:0]        pp;
    logic [63:0]        pp_ext, pp_shift, acc_mul;
    logic [32:0]        div_shift;
    logic               div_ge;
    logic [31:0]        div_rem;
    logic [63:0]        acc_scaled;
    logic [31:0]        term_sat;
    logic signed [33:0] int_sum, total_sum;

    assign dt_in  = in_time - last_time_reg;
    assign err_in = 33'(in_setpoint) - 33'(in_value);
    assign nd_in  = 33'(last_input_reg) - 33'(in_value);

    always_comb
    begin
        case (prod_reg)
            pcc_pkg::PROD_P: gain = kp_reg;
            pcc_pkg::PROD_I: gain = ki_reg;
            default:         gain = kd_reg;
        endcase
    end

    assign gain_mag = gain[31] ? (32'd0 - gain) : gain;
    assign x_mag    = (prod_reg == pcc_pkg::PROD_D) ? nd_mag_reg : err_mag_reg;
    assign prod_neg = gain[31] ^ ((prod_reg == pcc_pkg::PROD_D) ? nd_neg_reg : err_neg_reg);

    // 33-bit multiplicand in three slices of 16, 16 and 1 bits
    always_comb
    begin
        case (phase_reg)
            2'd0:    chunk = x_mag[15:0];
            2'd1:    chunk = x_mag[31:16];
            default: chunk = {15'd0, x_mag[32]};
        endcase
    end

    assign pp     = gain_mag * chunk;
    assign pp_ext = {16'd0, pp};

    always_comb
    begin
        case (phase_reg)
            2'd0:    pp_shift = pp_ext;
            2'd1:    pp_shift = {pp_ext[47:0], 16'd0};
            default: pp_shift = {pp_ext[31:0], 32'd0};
        endcase
    end

    assign acc_mul = acc_reg + pp_shift;

    // Restoring divide step: remainder always stays below dt
    assign div_shift = {rem_reg, acc_reg[63]};
    assign div_ge    = div_shift >= {1'b0, dt_reg};
    assign div_rem   = div_ge ? 32'(div_shift - {1'b0, dt_reg}) : div_shift[31:0];

    assign acc_scaled = acc_reg >> FRAC_BITS;
    assign term_sat   = pcc_pkg::sat_mag(acc_scaled,
                            (state_reg == pcc_pkg::ST_DSAT) ? (kd_reg[31] ^ nd_neg_reg)
                                                            : prod_neg);

    assign int_sum   = 34'(integral_reg) + 34'(iterm_reg);
    assign total_sum = 34'(p_reg) + 34'(integral_reg) + 34'(d_reg);

    // Next-state logic
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pcc_pkg::ST_IDLE:
            begin
                if (in_accept && in_opcode == pcc_pkg::OPC_COMPUTE)
                begin
                    state_next = dt_zero ? pcc_pkg::ST_EMIT : pcc_pkg::ST_MUL;
                end
            end
            pcc_pkg::ST_MUL:
            begin
                if (mul_last)
                begin
                    state_next = pcc_pkg::ST_STORE;
                end
            end
            pcc_pkg::ST_STORE:
            begin
                case (prod_reg)
                    pcc_pkg::PROD_P: state_next = pcc_pkg::ST_MUL;
                    pcc_pkg::PROD_I: state_next = pcc_pkg::ST_INT;
                    default:         state_next = pcc_pkg::ST_DIV;
                endcase
            end
            pcc_pkg::ST_INT:   state_next = pcc_pkg::ST_MUL;
            pcc_pkg::ST_DIV:
            begin
                if (div_last)
                begin
                    state_next = pcc_pkg::ST_DSAT;
                end
            end
            pcc_pkg::ST_DSAT:  state_next = pcc_pkg::ST_SUM;
            pcc_pkg::ST_SUM:   state_next = pcc_pkg::ST_CLAMP;
            pcc_pkg::ST_CLAMP: state_next = pcc_pkg::ST_EMIT;
            pcc_pkg::ST_EMIT:
            begin
                if (out_load)
                begin
                    state_next = pcc_pkg::ST_IDLE;
                end
            end
            default:           state_next = pcc_pkg::ST_IDLE;
        endcase
    end

    // Control outputs
    always_comb
    begin
        s_tready  = (state_reg == pcc_pkg::ST_IDLE);
        in_accept = s_tvalid && s_tready;
        dt_zero   = (dt_in == 32'd0);
        mul_last  = (phase_reg == 2'd2);
        div_last  = (cnt_reg == 6'd63);
        out_load  = (state_reg == pcc_pkg::ST_EMIT) && (!out_valid_reg || m_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= pcc_pkg::ST_IDLE;
            prod_reg       <= pcc_pkg::PROD_P;
            phase_reg      <= 2'd0;
            cnt_reg        <= 6'd0;
            integral_reg   <= 32'sd0;
            last_input_reg <= 32'sd0;
            last_time_reg  <= 32'd0;
            kp_reg         <= 32'sd0;
            ki_reg         <= 32'sd0;
            kd_reg         <= 32'sd0;
            min_reg        <= 32'sd0;
            max_reg        <= 32'sd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                case (cfg_index)
                    pcc_pkg::REG_KP:      kp_reg  <= cfg_data;
                    pcc_pkg::REG_KI:      ki_reg  <= cfg_data;
                    pcc_pkg::REG_KD:      kd_reg  <= cfg_data;
                    pcc_pkg::REG_OUT_MIN: min_reg <= cfg_data;
                    pcc_pkg::REG_OUT_MAX: max_reg <= cfg_data;
                    default:              ;
                endcase
            end

            if (in_accept)
            begin
                if (in_opcode == pcc_pkg::OPC_RESET)
                begin
                    last_input_reg <= in_value;
                    integral_reg   <= pcc_pkg::clamp(in_preset, min_reg, max_reg);
                    last_time_reg  <= in_time;
                end
                else if (!dt_zero)
                begin
                    last_input_reg <= in_value;
                    last_time_reg  <= in_time;
                    prod_reg       <= pcc_pkg::PROD_P;
                    phase_reg      <= 2'd0;
                end
            end

            case (state_reg)
                pcc_pkg::ST_MUL:
                begin
                    phase_reg <= mul_last ? 2'd0 : phase_reg + 2'd1;
                end
                pcc_pkg::ST_STORE:
                begin
                    if (prod_reg == pcc_pkg::PROD_P)
                    begin
                        prod_reg <= pcc_pkg::PROD_I;
                    end
                    cnt_reg <= 6'd0;
                end
                pcc_pkg::ST_INT:
                begin
                    integral_reg <= pcc_pkg::clamp(pcc_pkg::sat34(int_sum), min_reg, max_reg);
                    prod_reg     <= pcc_pkg::PROD_D;
                end
                pcc_pkg::ST_DIV:
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                end
                default: ;
            endcase

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept && in_opcode == pcc_pkg::OPC_COMPUTE)
        begin
            dt_reg       <= dt_in;
            err_neg_reg  <= err_in[32];
            err_mag_reg  <= err_in[32] ? (33'd0 - err_in) : err_in;
            nd_neg_reg   <= nd_in[32];
            nd_mag_reg   <= nd_in[32] ? (33'd0 - nd_in) : nd_in;
            acc_reg      <= 64'd0;
            res_reg      <= integral_reg;
            res_held_reg <= 1'b1;
        end

        case (state_reg)
            pcc_pkg::ST_MUL:
            begin
                acc_reg <= acc_mul;
            end
            pcc_pkg::ST_STORE:
            begin
                rem_reg <= 32'd0;
                case (prod_reg)
                    pcc_pkg::PROD_P:
                    begin
                        p_reg   <= term_sat;
                        acc_reg <= 64'd0;
                    end
                    pcc_pkg::PROD_I:
                    begin
                        iterm_reg <= term_sat;
                        acc_reg   <= 64'd0;
                    end
                    default: ;
                endcase
            end
            pcc_pkg::ST_DIV:
            begin
                rem_reg <= div_rem;
                acc_reg <= {acc_reg[62:0], div_ge};
            end
            pcc_pkg::ST_DSAT:
            begin
                d_reg <= term_sat;
            end
            pcc_pkg::ST_SUM:
            begin
                sum_reg <= pcc_pkg::sat34(total_sum);
            end
            pcc_pkg::ST_CLAMP:
            begin
                res_reg      <= pcc_pkg::clamp(sum_reg, min_reg, max_reg);
                res_held_reg <= 1'b0;
            end
            default: ;
        endcase

        if (out_load)
        begin
            out_data_reg <= res_reg;
            out_held_reg <= res_held_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_held_reg;

endmodule
